### hdl/bounded_byte_stream_fifo_macros.svh
// assertion macros for the bounded byte fifo checker
// no dependencies; included by the checker file
`ifndef BOUNDED_BYTE_STREAM_FIFO_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_MACROS_SVH

// same-cycle implication, off while in reset
`define BBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bbf check failed");

// next-cycle implication, off while in reset
`define BBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bbf check failed");

// next-cycle implication that also holds across reset
`define BBF_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bbf check failed");

`endif

### hdl/bbf_pkg.sv
// shared constants and command codes for the bounded byte fifo
// no dependencies
package bbf_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 7;
    localparam int TOT_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_END   = 3'd4;

endpackage

### hdl/bounded_byte_stream_fifo.sv
// bounded byte fifo: command decode, pointer and count update, byte emit sequencer
// depends on bbf_pkg and bbf_ram
//
// Usage: one command beat on the input channel (i_in_valid/o_in_ready) carries a
// mode, a byte and a length. Write stores one byte if there is room; read pops and
// emits up to length bytes; peek emits without popping; pop discards; end raises
// a sticky flag. Results leave on the output channel (o_out_valid/i_out_ready),
// one beat per emitted byte, with o_last on the final beat of a command; commands
// that emit nothing give one status beat. Capacity is set by i_cfg_we/i_cfg_data;
// the user must write it only while the block is idle; the block does not enforce it.
// Sequencing: a status-only command shows its beat in the cycle after acceptance.
// A read or peek first reads the head byte through the registered ram port, then
// loads the output register, and then emits one byte a cycle while the receiver
// takes them, since the emit loop walks the byte ram one address a cycle.
// The next command is taken once the last beat of the previous one is leaving.
// Reset: buffer empty, counters and flags cleared, capacity 64, output empty.
// A stalled receiver holds the current beat and freezes the emit loop.
module bounded_byte_stream_fifo
    import bbf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [BYTE_W-1:0] i_write_byte,
    input  logic [LEN_W-1:0]  i_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_last,
    output logic              o_write_accepted,
    output logic [CNT_W-1:0]  o_fill_level,
    output logic [CNT_W-1:0]  o_room_left,
    output logic              o_ended,
    output logic              o_at_eof,
    output logic              o_error_flag,
    output logic [TOT_W-1:0]  o_total_written,
    output logic [TOT_W-1:0]  o_total_popped,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              r_state,     n_state;
    logic [AW-1:0]     r_head,      n_head;
    logic [CNT_W-1:0]  r_fill,      n_fill;
    logic [TOT_W-1:0]  r_tw,        n_tw;
    logic [TOT_W-1:0]  r_tr,        n_tr;
    logic              r_ended,     n_ended;
    logic              r_err,       n_err;
    logic [CAP_W-1:0]  r_cap;
    logic              r_wacc,      n_wacc;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;
    logic              r_bvalid,    n_bvalid;
    logic              r_last,      n_last;
    logic [AW-1:0]     r_rd_ptr,    n_rd_ptr;
    logic [CNT_W-1:0]  r_remain,    n_remain;

    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  room;
    logic              out_free;
    logic              accept;
    logic              len_over;
    logic [CNT_W-1:0]  take;
    logic              wr_ok;
    logic [SW-1:0]     wr_sum;
    logic [AW-1:0]     wr_addr;
    logic [SW-1:0]     adv_sum;
    logic [AW-1:0]     head_adv;
    logic              ram_we;
    logic [BYTE_W-1:0] rd_data;

    assign eff_cap  = (r_cap > DEPTH_C) ? DEPTH_C : r_cap;
    assign room     = (eff_cap > r_fill) ? (eff_cap - r_fill) : '0;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept   = i_in_valid && o_in_ready;

    assign len_over = i_length > LEN_W'(eff_cap);
    assign take     = (i_length < LEN_W'(r_fill)) ? i_length[CNT_W-1:0] : r_fill;
    assign wr_ok    = (room != '0) && (r_fill < DEPTH_C);

    // tail slot and advanced head, both below twice the depth
    assign wr_sum   = SW'(r_head) + SW'(r_fill);
    assign wr_addr  = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);
    assign adv_sum  = SW'(r_head) + SW'(take);
    assign head_adv = (adv_sum >= DEPTH_S) ? AW'(adv_sum - DEPTH_S) : AW'(adv_sum);

    assign ram_we = accept && (i_mode == MODE_WRITE) && wr_ok;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_tw        = r_tw;
        n_tr        = r_tr;
        n_ended     = r_ended;
        n_err       = r_err;
        n_wacc      = r_wacc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_bvalid    = r_bvalid;
        n_last      = r_last;
        n_rd_ptr    = r_rd_ptr;
        n_remain    = r_remain;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // default: one status beat
                    n_wacc      = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_bvalid    = 1'b0;
                    n_last      = 1'b1;
                    case (i_mode)
                        MODE_WRITE: begin
                            if (wr_ok) begin
                                n_fill = r_fill + 1'b1;
                                n_tw   = r_tw + 1'b1;
                                n_wacc = 1'b1;
                            end
                        end
                        MODE_READ, MODE_PEEK: begin
                            if ((i_mode == MODE_READ) && len_over) begin
                                n_err = 1'b1;
                            end else begin
                                if (i_mode == MODE_READ) begin
                                    n_head = head_adv;
                                    n_fill = r_fill - take;
                                    n_tr   = r_tr + TOT_W'(take);
                                end
                                if (take != '0) begin
                                    n_out_valid = 1'b0;
                                    n_rd_ptr    = r_head;
                                    n_remain    = take;
                                    n_state     = ST_EMIT;
                                end
                            end
                        end
                        MODE_POP: begin
                            if (len_over) begin
                                n_err = 1'b1;
                            end else begin
                                n_head = head_adv;
                                n_fill = r_fill - take;
                                n_tr   = r_tr + TOT_W'(take);
                            end
                        end
                        MODE_END: begin
                            n_ended = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = rd_data;
                    n_bvalid    = 1'b1;
                    n_last      = (r_remain == CNT_W'(1));
                    n_remain    = r_remain - 1'b1;
                    n_rd_ptr    = (r_rd_ptr == LAST_A) ? '0 : r_rd_ptr + 1'b1;
                    if (r_remain == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_tw        <= '0;
            r_tr        <= '0;
            r_ended     <= 1'b0;
            r_err       <= 1'b0;
            r_cap       <= CAP_RESET;
            r_wacc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_tw        <= n_tw;
            r_tr        <= n_tr;
            r_ended     <= n_ended;
            r_err       <= n_err;
            r_wacc      <= n_wacc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_bvalid   <= n_bvalid;
        r_last     <= n_last;
        r_rd_ptr   <= n_rd_ptr;
        r_remain   <= n_remain;
    end

    // read address is taken from n_rd_ptr so the registered data matches r_rd_ptr
    bbf_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_write_byte),
        .i_rd_addr (n_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_byte_valid     = r_bvalid;
    assign o_last           = r_last;
    assign o_write_accepted = r_wacc;
    assign o_fill_level     = r_fill;
    assign o_room_left      = room;
    assign o_ended          = r_ended;
    assign o_at_eof         = r_ended && (r_fill == '0);
    assign o_error_flag     = r_err;
    assign o_total_written  = r_tw;
    assign o_total_popped   = r_tr;

endmodule

### hdl/bbf_ram.sv
// byte storage for the bounded byte fifo: one write port, one registered read port
// depends on bbf_pkg
module bbf_ram
    import bbf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bbf_checker.sv
// port-level checks for the bounded byte fifo, bound to the top level
// depends on bbf_pkg and bounded_byte_stream_fifo_macros.svh
`include "bounded_byte_stream_fifo_macros.svh"

module bbf_checker
    import bbf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_last,
    input logic [CNT_W-1:0]  o_fill_level,
    input logic              o_ended,
    input logic              o_at_eof,
    input logic              o_error_flag
);

    logic              out_stall;
    logic [BYTE_W:0]   out_word;

    // a held beat keeps its payload
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_last, o_out_byte};

    `BBF_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)
    `BBF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word))
    `BBF_ASSERT_NXT(a_err_sticky, i_clk, i_rst_n, o_error_flag, o_error_flag)
    `BBF_ASSERT_IMP(a_eof_empty, i_clk, i_rst_n, o_at_eof, o_ended && (o_fill_level == '0))
    `BBF_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, o_out_valid, o_fill_level <= CNT_W'(DEPTH))

endmodule

bind bounded_byte_stream_fifo bbf_checker #(
    .DEPTH (DEPTH)
) u_bbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_last       (o_last),
    .o_fill_level (o_fill_level),
    .o_ended      (o_ended),
    .o_at_eof     (o_at_eof),
    .o_error_flag (o_error_flag)
);

### test/tb_bounded_byte_stream_fifo.sv
// self-checking testbench for the bounded byte fifo: directed and random command streams
// with a local predictor of the buffer, random stalls on both channels and a long hold-off
// depends on bbf_pkg and bounded_byte_stream_fifo
module tb_bounded_byte_stream_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import bbf_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int ITEMS_PER_CAP  = 17;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_NS     = 3_000_000;
    localparam int EXP_DEPTH      = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              byte_valid;
        logic              last;
        logic              wr_acc;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  room;
        logic              ended;
        logic              eof;
        logic              err;
        logic [TOT_W-1:0]  tot_wr;
        logic [TOT_W-1:0]  tot_rd;
    } beat_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode = MODE_WRITE;
    logic [BYTE_W-1:0] i_write_byte = '0;
    logic [LEN_W-1:0]  i_length = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_byte_valid;
    logic              o_last;
    logic              o_write_accepted;
    logic [CNT_W-1:0]  o_fill_level;
    logic [CNT_W-1:0]  o_room_left;
    logic              o_ended;
    logic              o_at_eof;
    logic              o_error_flag;
    logic [TOT_W-1:0]  o_total_written;
    logic [TOT_W-1:0]  o_total_popped;
    logic              i_cfg_we = 1'b0;
    logic [CAP_W-1:0]  i_cfg_data = '0;

    // predicted buffer state
    logic [BYTE_W-1:0] fifo_mem [DEPTH_DEF];
    int unsigned       fifo_head;
    int unsigned       fifo_fill;
    logic [TOT_W-1:0]  bytes_in_total;
    logic [TOT_W-1:0]  bytes_out_total;
    logic              end_declared;
    logic              sticky_err;
    logic [CAP_W-1:0]  cap_reg;

    // ring of expected beats
    beat_t awaited_beats [EXP_DEPTH];
    int    exp_rd_idx;
    int    exp_wr_idx;
    int    awaited_count;
    int    cmds_sent;
    int    beats_checked;
    int    mismatches;
    int    caps_written;
    int    burst_left;
    int    hold_requests;

    bounded_byte_stream_fifo uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_write_byte     (i_write_byte),
        .i_length         (i_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last),
        .o_write_accepted (o_write_accepted),
        .o_fill_level     (o_fill_level),
        .o_room_left      (o_room_left),
        .o_ended          (o_ended),
        .o_at_eof         (o_at_eof),
        .o_error_flag     (o_error_flag),
        .o_total_written  (o_total_written),
        .o_total_popped   (o_total_popped),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d beats still awaited", awaited_count);
        $display("FAILURE");
        $finish;
    end

    function automatic void add_expected(beat_t bt);
        awaited_beats[exp_wr_idx] = bt;
        exp_wr_idx    = (exp_wr_idx + 1) % EXP_DEPTH;
        awaited_count = awaited_count + 1;
    endfunction

    function automatic beat_t next_expected();
        beat_t bt;
        bt            = awaited_beats[exp_rd_idx];
        exp_rd_idx    = (exp_rd_idx + 1) % EXP_DEPTH;
        awaited_count = awaited_count - 1;
        return bt;
    endfunction

    function automatic int unsigned eff_capacity();
        return (cap_reg > DEPTH_DEF) ? DEPTH_DEF : cap_reg;
    endfunction

    function automatic void drop_bytes(int unsigned n);
        fifo_head       = (fifo_head + n) % DEPTH_DEF;
        fifo_fill       = fifo_fill - n;
        bytes_out_total = bytes_out_total + n;
    endfunction

    // queues the beats one command produces and advances the buffer state
    function automatic void predict_fifo_command(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] b,
                                                 logic [LEN_W-1:0] l);
        beat_t             bt;
        logic [BYTE_W-1:0] emitted [DEPTH_DEF];
        int unsigned       ecap;
        int unsigned       n;
        logic              wr_acc;
        ecap   = eff_capacity();
        wr_acc = 1'b0;
        n      = 0;
        case (m)
            MODE_WRITE: begin
                if (fifo_fill < ecap) begin
                    fifo_mem[(fifo_head + fifo_fill) % DEPTH_DEF] = b;
                    fifo_fill      = fifo_fill + 1;
                    bytes_in_total = bytes_in_total + 1;
                    wr_acc         = 1'b1;
                end
            end
            MODE_READ, MODE_PEEK: begin
                if (m == MODE_READ && l > ecap) begin
                    sticky_err = 1'b1;
                end else begin
                    n = (l < fifo_fill) ? l : fifo_fill;
                    for (int i = 0; i < n; i++)
                        emitted[i] = fifo_mem[(fifo_head + i) % DEPTH_DEF];
                    if (m == MODE_READ)
                        drop_bytes(n);
                end
            end
            MODE_POP: begin
                if (l > ecap)
                    sticky_err = 1'b1;
                else
                    drop_bytes((l < fifo_fill) ? l : fifo_fill);
            end
            MODE_END: end_declared = 1'b1;
            default: ;
        endcase
        bt.fill   = CNT_W'(fifo_fill);
        bt.room   = CNT_W'((ecap > fifo_fill) ? ecap - fifo_fill : 0);
        bt.ended  = end_declared;
        bt.eof    = end_declared && (fifo_fill == 0);
        bt.err    = sticky_err;
        bt.tot_wr = bytes_in_total;
        bt.tot_rd = bytes_out_total;
        if (n == 0) begin
            bt.data       = '0;
            bt.byte_valid = 1'b0;
            bt.last       = 1'b1;
            bt.wr_acc     = wr_acc;
            add_expected(bt);
        end else begin
            for (int i = 0; i < n; i++) begin
                bt.data       = emitted[i];
                bt.byte_valid = 1'b1;
                bt.last       = (i == n - 1);
                bt.wr_acc     = 1'b0;
                add_expected(bt);
            end
        end
    endfunction

    // output beat checker
    always @(posedge i_clk) begin : beat_checker
        beat_t got;
        beat_t want;
        string diff;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_byte, o_byte_valid, o_last, o_write_accepted, o_fill_level,
                    o_room_left, o_ended, o_at_eof, o_error_flag, o_total_written,
                    o_total_popped};
            if (awaited_count == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: got %h", got);
            end else begin
                want = next_expected();
                diff = "";
                if (got.data !== want.data) diff = {diff, " out_byte"};
                if (got.byte_valid !== want.byte_valid) diff = {diff, " byte_valid"};
                if (got.last !== want.last) diff = {diff, " last"};
                if (got.wr_acc !== want.wr_acc) diff = {diff, " write_accepted"};
                if (got.fill !== want.fill) diff = {diff, " fill_level"};
                if (got.room !== want.room) diff = {diff, " room_left"};
                if (got.ended !== want.ended) diff = {diff, " ended"};
                if (got.eof !== want.eof) diff = {diff, " at_eof"};
                if (got.err !== want.err) diff = {diff, " error_flag"};
                if (got.tot_wr !== want.tot_wr) diff = {diff, " total_written"};
                if (got.tot_rd !== want.tot_rd) diff = {diff, " total_popped"};
                if (diff != "") begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("beat %0d mismatch in%s: expected %h got %h",
                                 beats_checked, diff, want, got);
                end
            end
            beats_checked++;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : out_ready_pattern
        int phase_left;
        int ready_pct;
        int hold_left;
        int hold_seen;
        phase_left = 0;
        ready_pct  = 100;
        hold_left  = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(4, 40);
                    case ($urandom_range(3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                phase_left--;
                i_out_ready <= ($urandom_range(99) < ready_pct);
            end
        end
    end

    // sender bursts: valid stays up inside a burst, drops for a random gap between bursts
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
        end
    endtask

    task automatic send_cmd(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] l);
        i_in_valid   <= 1'b1;
        i_mode       <= m;
        i_write_byte <= b;
        i_length     <= l;
        do @(posedge i_clk); while (!o_in_ready);
        predict_fifo_command(m, b, l);
        cmds_sent++;
        pace_sender();
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_count != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg = c;
        caps_written++;
    endtask

    task automatic test_idle_commands();
        send_cmd(MODE_RSVD5, 8'hFF, 10'h3FF);
        send_cmd(MODE_RSVD6, 8'h00, 10'h000);
        send_cmd(MODE_RSVD7, 8'hFF, 10'h3FF);
        send_cmd(MODE_READ, 8'h00, 10'd0);
        send_cmd(MODE_PEEK, 8'h00, 10'd64);
    endtask

    task automatic test_byte_path();
        send_cmd(MODE_WRITE, 8'h00, 10'd0);
        send_cmd(MODE_WRITE, 8'hFF, 10'h3FF);
        send_cmd(MODE_WRITE, 8'h5A, 10'd0);
        send_cmd(MODE_WRITE, 8'hA5, 10'd0);
        // peek never raises the error, even far above capacity
        send_cmd(MODE_PEEK, 8'h00, 10'h3FF);
        send_cmd(MODE_READ, 8'h00, 10'd2);
        send_cmd(MODE_POP, 8'h00, 10'd1);
        send_cmd(MODE_READ, 8'h00, 10'd64);
    endtask

    task automatic test_capacity_limits();
        set_capacity(CAP_W'(1));
        send_cmd(MODE_WRITE, 8'h11, 10'd0);
        send_cmd(MODE_WRITE, 8'h22, 10'd0);
        send_cmd(MODE_READ, 8'h00, 10'd1);
        // zero capacity refuses every write
        set_capacity(CAP_W'(0));
        send_cmd(MODE_WRITE, 8'h33, 10'd0);
        send_cmd(MODE_POP, 8'h00, 10'd0);
        set_capacity(CAP_W'(127));
        send_cmd(MODE_WRITE, 8'h44, 10'd0);
        send_cmd(MODE_WRITE, 8'h55, 10'd0);
        // capacity below fill: nothing lost, room reads zero
        set_capacity(CAP_W'(1));
        send_cmd(MODE_WRITE, 8'h66, 10'd0);
        send_cmd(MODE_READ, 8'h00, 10'd1);
    endtask

    task automatic test_end_and_errors();
        set_capacity(CAP_RESET);
        send_cmd(MODE_END, 8'h00, 10'd0);
        send_cmd(MODE_WRITE, 8'h77, 10'd0);
        send_cmd(MODE_READ, 8'h00, 10'd64);
        send_cmd(MODE_POP, 8'h00, 10'd65);
        send_cmd(MODE_READ, 8'h00, 10'h3FF);
    endtask

    task automatic test_random_traffic();
        int unsigned cap_plan [12] = '{64, 1, 2, 5, 0, 127, 13, 40, 64, 100, 31, 9};
        int unsigned ecap;
        int unsigned lim;
        int unsigned r;
        logic [MODE_W-1:0] m;
        logic [LEN_W-1:0]  l;
        for (int p = 0; p < 12; p++) begin
            set_capacity(CAP_W'((p == 11) ? $urandom_range(0, 127) : cap_plan[p]));
            repeat (ITEMS_PER_CAP) begin
                ecap = eff_capacity();
                lim  = (fifo_fill + 2 > ecap) ? ecap : fifo_fill + 2;
                r = $urandom_range(99);
                if (r < 45)      m = MODE_WRITE;
                else if (r < 62) m = MODE_READ;
                else if (r < 74) m = MODE_PEEK;
                else if (r < 86) m = MODE_POP;
                else if (r < 89) m = MODE_END;
                else if (r < 94) m = MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
                else             m = MODE_W'($urandom_range(MODE_RSVD7));
                r = $urandom_range(99);
                if (r < 70)      l = LEN_W'($urandom_range(0, lim));
                else if (r < 85) l = LEN_W'($urandom_range(0, ecap));
                else if (r < 95) l = LEN_W'($urandom_range(0, 1023));
                else             l = LEN_W'(ecap + 1);
                send_cmd(m, BYTE_W'($urandom_range(255)), l);
            end
        end
    endtask

    task automatic test_backpressure();
        set_capacity(CAP_W'(64));
        hold_requests++;
        // sender keeps offering while the receiver holds off
        burst_left = 1000;
        repeat (80) send_cmd(MODE_WRITE, BYTE_W'($urandom_range(255)), 10'd0);
        burst_left = 0;
        send_cmd(MODE_PEEK, 8'h00, 10'd64);
        send_cmd(MODE_READ, 8'h00, 10'd64);
    endtask

    initial begin
        fifo_head       = 0;
        fifo_fill       = 0;
        bytes_in_total  = '0;
        bytes_out_total = '0;
        end_declared    = 1'b0;
        sticky_err      = 1'b0;
        cap_reg         = CAP_RESET;
        exp_rd_idx      = 0;
        exp_wr_idx      = 0;
        awaited_count   = 0;
        cmds_sent       = 0;
        beats_checked   = 0;
        mismatches      = 0;
        caps_written    = 0;
        burst_left      = 0;
        hold_requests   = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_commands();
        test_byte_path();
        test_capacity_limits();
        test_end_and_errors();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d result beats checked", cmds_sent, beats_checked);
        $display("%0d capacity writes, receiver hold-off exercised %0d time(s)",
                 caps_written, hold_requests);
        if (mismatches == 0 && awaited_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d beats never seen", mismatches, awaited_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/bbf_pkg.sv
hdl/bbf_ram.sv
hdl/bounded_byte_stream_fifo.sv
hdl/bbf_checker.sv
test/tb_bounded_byte_stream_fifo.sv
